### rtl/lru_tile_tag_store_core_assert.svh
// Assertion macros for the tile tag store
`ifndef LRU_TILE_TAG_STORE_CORE_ASSERT_SVH
`define LRU_TILE_TAG_STORE_CORE_ASSERT_SVH
`define LTS_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define LTS_ASSERT_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`endif

### rtl/lts_pkg.sv
// ----------------------------------------------------------------------------
// lts_pkg
// Shared types and codes of the tile tag store.
// ----------------------------------------------------------------------------
package lts_pkg;
  localparam int KEY_W = 17;
  localparam logic [KEY_W-1:0] EMPTY_TAG = '1;
  localparam logic [1:0] OUT_LOADED = 2'd0;
  localparam logic [1:0] OUT_ABSENT = 2'd1;
  localparam logic [1:0] OUT_IO_ERROR = 2'd2;
  localparam logic [2:0] ST_HIT_DATA = 3'd0;
  localparam logic [2:0] ST_HIT_MISSING = 3'd1;
  localparam logic [2:0] ST_MISS_LOADED = 3'd2;
  localparam logic [2:0] ST_MISS_MISSING = 3'd3;
  localparam logic [2:0] ST_IO_ERROR = 3'd4;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [1:0] outcome;
  } req_t;
endpackage

### rtl/lts_if.sv
// ----------------------------------------------------------------------------
// lts_req_if / lts_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface lts_req_if;
  logic valid;
  logic ready;
  logic signed [7:0] latitude_floor;
  logic signed [8:0] longitude_floor;
  logic [1:0] load_outcome;
  modport source (output valid, latitude_floor, longitude_floor, load_outcome, input ready);
  modport sink (input valid, latitude_floor, longitude_floor, load_outcome, output ready);
endinterface

interface lts_rsp_if;
  logic valid;
  logic ready;
  logic [2:0] status;
  logic [3:0] slot_index;
  modport source (output valid, status, slot_index, input ready);
  modport sink (input valid, status, slot_index, output ready);
endinterface

### rtl/lts_front.sv
// ----------------------------------------------------------------------------
// lts_front
// Accept requests, pack the key, and queue them for the back end.
// ----------------------------------------------------------------------------
module lts_front #(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  lts_req_if.sink req,
  output logic q_valid,
  input  logic q_pop,
  output lts_pkg::req_t q_head
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  lts_pkg::req_t buf_mem [DEPTH];
  logic [AW-1:0] wptr, rptr;
  logic [AW:0] count;
  lts_pkg::req_t packed_req;
  logic push;

  always_comb begin
    packed_req.key = {8'(req.latitude_floor + 8'sd90), 9'(req.longitude_floor + 9'sd180)};
    packed_req.outcome = req.load_outcome;
  end

  assign req.ready = (count != (AW+1)'(DEPTH));
  assign push = req.valid && req.ready;
  assign q_valid = (count != '0);
  assign q_head = buf_mem[rptr];

  always_ff @(posedge clk) begin
    if (push) buf_mem[wptr] <= packed_req;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == AW'(DEPTH-1)) ? '0 : wptr + 1'b1;
      if (q_pop) rptr <= (rptr == AW'(DEPTH-1)) ? '0 : rptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(q_pop);
    end
  end

`include "lru_tile_tag_store_core_assert.svh"
  `LTS_ASSERT(a_no_underflow, !(q_pop && count == '0), "pop from empty queue")
  `LTS_ASSERT(a_count_bound, count <= (AW+1)'(DEPTH), "queue over depth")
  `LTS_ASSERT_IMPL(a_push_counts, push && !q_pop, count == $past(count) + 1'b1, "push lost")
endmodule

### rtl/lts_back.sv
// ----------------------------------------------------------------------------
// lts_back
// Tag compare, replacement and recency update; holds the result register.
// ----------------------------------------------------------------------------
module lts_back #(
  parameter int SLOT_COUNT = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_pop,
  input  lts_pkg::req_t q_head,
  lts_rsp_if.source rsp
);
  localparam int IW = $clog2(SLOT_COUNT);
  localparam int LW = $clog2(SLOT_COUNT + 1);
  localparam logic [LW-1:0] NUL = LW'(SLOT_COUNT);
  localparam logic [1:0] S_IDLE = 2'd0, S_CMP = 2'd1, S_UPD = 2'd2, S_OUT = 2'd3;

  logic [lts_pkg::KEY_W-1:0] tag [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] miss_mark;
  logic [LW-1:0] older [SLOT_COUNT];
  logic [LW-1:0] newer [SLOT_COUNT];
  logic [IW-1:0] most_recent, least_recent;
  logic [1:0] state;
  lts_pkg::req_t cur;
  logic hit_r;
  logic [IW-1:0] idx_r;
  logic [SLOT_COUNT-1:0] match;
  logic [IW-1:0] hit_idx;
  logic hit_any;
  logic [2:0] status_r;
  logic do_promote;

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++)
      match[i] = (tag[i] != lts_pkg::EMPTY_TAG) && (tag[i] == cur.key);
    hit_any = |match;
    hit_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--)
      if (match[i]) hit_idx = IW'(i);
  end

  assign q_pop = (state == S_IDLE) && q_valid;
  assign rsp.valid = (state == S_OUT);
  assign rsp.status = status_r;
  assign rsp.slot_index = 4'(idx_r);

  always_comb begin
    if (hit_r) do_promote = !miss_mark[idx_r];
    else do_promote = (cur.outcome == lts_pkg::OUT_LOADED)
                   || (cur.outcome == lts_pkg::OUT_ABSENT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      most_recent <= '0;
      least_recent <= IW'(SLOT_COUNT - 1);
      miss_mark <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        tag[i] <= lts_pkg::EMPTY_TAG;
        older[i] <= (i == SLOT_COUNT - 1) ? NUL : LW'(i + 1);
        newer[i] <= (i == 0) ? NUL : LW'(i - 1);
      end
    end else begin
      unique case (state)
        S_IDLE: if (q_valid) begin
          cur <= q_head;
          state <= S_CMP;
        end
        S_CMP: begin
          hit_r <= hit_any;
          idx_r <= hit_any ? hit_idx : least_recent;
          state <= S_UPD;
        end
        S_UPD: begin
          if (hit_r) begin
            status_r <= miss_mark[idx_r] ? lts_pkg::ST_HIT_MISSING : lts_pkg::ST_HIT_DATA;
          end else begin
            // evict the tail slot and maybe refill it
            tag[idx_r] <= do_promote ? cur.key : lts_pkg::EMPTY_TAG;
            miss_mark[idx_r] <= do_promote && cur.outcome[0];
            status_r <= !do_promote ? lts_pkg::ST_IO_ERROR
                      : (cur.outcome[0] ? lts_pkg::ST_MISS_MISSING : lts_pkg::ST_MISS_LOADED);
          end
          if (do_promote && idx_r != most_recent) begin
            if (newer[idx_r] != NUL) older[IW'(newer[idx_r])] <= older[idx_r];
            if (older[idx_r] != NUL) newer[IW'(older[idx_r])] <= newer[idx_r];
            if (idx_r == least_recent && newer[idx_r] != NUL)
              least_recent <= IW'(newer[idx_r]);
            newer[idx_r] <= NUL;
            older[idx_r] <= LW'(most_recent);
            newer[most_recent] <= LW'(idx_r);
            most_recent <= idx_r;
          end
          state <= S_OUT;
        end
        S_OUT: if (rsp.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

`include "lru_tile_tag_store_core_assert.svh"
  `LTS_ASSERT(a_pop_idle, !q_pop || state == S_IDLE, "pop while busy")
  `LTS_ASSERT_IMPL(a_cmp_next, state == S_CMP, state == S_UPD, "compare not followed by update")
  `LTS_ASSERT(a_match_onehot, $onehot0(match), "duplicate tags")
endmodule

### rtl/lru_tile_tag_store_core.sv
// ----------------------------------------------------------------------------
// lru_tile_tag_store_core
// Fully associative tile tag store with LRU replacement.
// ----------------------------------------------------------------------------
// channel | dir | handshake   | payload
// req     | in  | valid/ready | latitude_floor, longitude_floor, load_outcome
// rsp     | out | valid/ready | status, slot_index
// Each request passes the back end as pop, tag compare, list update and
// result; the next request is popped only after the result is taken.
// The front queue keeps taking requests while a result waits.
// Synchronous reset restores the empty store and the index-ordered list.
// A stalled result holds the back end; the queue fills, then req.ready drops.
module lru_tile_tag_store_core #(
  parameter int SLOT_COUNT = 16
) (
  input logic clk,
  input logic rst,
  lts_req_if.sink req,
  lts_rsp_if.source rsp
);
  logic q_valid, q_pop;
  lts_pkg::req_t q_head;

  lts_front #(.DEPTH(2)) u_front (
    .clk(clk), .rst(rst), .req(req), .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head)
  );
  lts_back #(.SLOT_COUNT(SLOT_COUNT)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head), .rsp(rsp)
  );
endmodule
